>>> design/pid_lfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_lfd_pkg
// shared types and constants of the line-follow pid drive
// ----------------------------------------------------------------------------
package pid_lfd_pkg;

    // apb register map: register i lies at byte address 4*i
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;
    localparam int FIELD_W = 16;

    typedef enum logic [1:0] {
        REG_KP_GAIN     = 2'd0,
        REG_KI_TIMES_DT = 2'd1,
        REG_KD_OVER_DT  = 2'd2,
        REG_CRUISE      = 2'd3
    } reg_index_t;

    // register reset values
    localparam logic [FIELD_W-1:0] KP_GAIN_RST     = 16'd282;
    localparam logic [FIELD_W-1:0] KI_TIMES_DT_RST = 16'd0;
    localparam logic [FIELD_W-1:0] KD_OVER_DT_RST  = 16'd1120;
    localparam logic [FIELD_W-1:0] CRUISE_RST      = 16'd15565;

    // q2.14 full scale and q8.8 rounding
    localparam int UNIT_ONE   = 16384;
    localparam int GAIN_FRAC  = 8;
    localparam int ROUND_HALF = 128;

endpackage

>>> design/pid_line_follow_drive.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_line_follow_drive
// discrete pid step per line-position sample, driving two motor speeds
// ----------------------------------------------------------------------------
// Each input beat carries one Q2.14 line error e. The block keeps the previous
// error and a saturating SUM_WIDTH-bit sum of errors, forms
// correction = round(kp*e + ki*sum + kd*(e - previous)) with Q8.8 gains
// (rounding half up), and returns left = base + correction and
// right = base - correction, each clamped to [-1.0, +1.0] with a flag when
// either side clamps. Throughput is one beat per clock unless the result
// side stalls: the error state is updated in the input stage, so a new
// sample can enter every cycle. A sample passes three registers: input/state
// stage, multiplier stage (three products registered in parallel), then the
// add/round/clamp stage into the output register. A stalled result holds
// the output register and the run of full stages right behind it; s_ready
// drops only once all three stages hold a beat. Gains and base speed sit in
// APB registers and must only be written while no sample is in flight.
// ----------------------------------------------------------------------------
module pid_line_follow_drive #(
    parameter int SUM_WIDTH = 24
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // sample input
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [15:0]                    s_line_position,
    // result output
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [15:0]                    m_left_drive,
    output logic signed [15:0]                    m_right_drive,
    output logic                                  m_clamped,
    // configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [pid_lfd_pkg::ADDR_W-1:0]        paddr,
    input  logic [pid_lfd_pkg::DATA_W-1:0]        pwdata,
    output logic [pid_lfd_pkg::DATA_W-1:0]        prdata,
    output logic                                  pready
);

    // product and accumulator widths
    localparam int PI_W   = SUM_WIDTH + 16;     // ki * sum
    localparam int PD_W   = 33;                 // kd * 17-bit difference
    localparam int ACC_W  = SUM_WIDTH + 18;     // three products plus headroom
    localparam int CORR_W = ACC_W - pid_lfd_pkg::GAIN_FRAC;
    localparam int LR_W   = CORR_W + 1;

    localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};
    localparam logic signed [LR_W-1:0] LIM_HI = LR_W'(pid_lfd_pkg::UNIT_ONE);
    localparam logic signed [LR_W-1:0] LIM_LO = -LR_W'(pid_lfd_pkg::UNIT_ONE);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic signed [15:0] kp_gain_reg;
    logic signed [15:0] ki_times_dt_reg;
    logic signed [15:0] kd_over_dt_reg;
    logic signed [15:0] cruise_reg;
    logic               cfg_write;
    pid_lfd_pkg::reg_index_t cfg_index;
    logic [15:0]        cfg_read;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = pid_lfd_pkg::reg_index_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_gain_reg     <= pid_lfd_pkg::KP_GAIN_RST;
            ki_times_dt_reg <= pid_lfd_pkg::KI_TIMES_DT_RST;
            kd_over_dt_reg  <= pid_lfd_pkg::KD_OVER_DT_RST;
            cruise_reg      <= pid_lfd_pkg::CRUISE_RST;
        end else if (cfg_write) begin
            unique case (cfg_index)
                pid_lfd_pkg::REG_KP_GAIN:     kp_gain_reg     <= pwdata[15:0];
                pid_lfd_pkg::REG_KI_TIMES_DT: ki_times_dt_reg <= pwdata[15:0];
                pid_lfd_pkg::REG_KD_OVER_DT:  kd_over_dt_reg  <= pwdata[15:0];
                pid_lfd_pkg::REG_CRUISE:      cruise_reg      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register readback, raw 16-bit value
    always_comb begin
        unique case (cfg_index)
            pid_lfd_pkg::REG_KP_GAIN:     cfg_read = kp_gain_reg;
            pid_lfd_pkg::REG_KI_TIMES_DT: cfg_read = ki_times_dt_reg;
            pid_lfd_pkg::REG_KD_OVER_DT:  cfg_read = kd_over_dt_reg;
            pid_lfd_pkg::REG_CRUISE:      cfg_read = cruise_reg;
            default:                      cfg_read = '0;
        endcase
    end

    assign prdata = {16'h0000, cfg_read};

    // ------------------------------------------------------------------
    // pipeline flow control: each stage moves when the one after it is free
    // ------------------------------------------------------------------
    logic a_valid_reg;
    logic b_valid_reg;
    logic m_valid_reg;
    logic out_free;
    logic b_free;
    logic a_free;
    logic in_beat;

    assign out_free = !m_valid_reg || m_ready;
    assign b_free   = !b_valid_reg || out_free;
    assign a_free   = !a_valid_reg || b_free;
    assign s_ready  = a_free;
    assign in_beat  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (a_free)   a_valid_reg <= s_valid;
            if (b_free)   b_valid_reg <= a_valid_reg;
            if (out_free) m_valid_reg <= b_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage a: error state update on every accepted beat
    // ------------------------------------------------------------------
    logic signed [15:0]          prev_error_reg;
    logic signed [SUM_WIDTH-1:0] error_sum_reg;
    logic signed [SUM_WIDTH:0]   sum_wide;
    logic signed [SUM_WIDTH-1:0] error_sum_next;
    logic signed [16:0]          diff_next;

    logic signed [15:0]          e_reg;
    logic signed [SUM_WIDTH-1:0] sum_reg;
    logic signed [16:0]          diff_reg;

    always_comb begin
        sum_wide = (SUM_WIDTH+1)'(error_sum_reg) + (SUM_WIDTH+1)'(s_line_position);
        // overflow when the two top bits disagree
        if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
            error_sum_next = sum_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
        end else begin
            error_sum_next = sum_wide[SUM_WIDTH-1:0];
        end
        diff_next = 17'(s_line_position) - 17'(prev_error_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_error_reg <= '0;
            error_sum_reg  <= '0;
        end else if (in_beat) begin
            prev_error_reg <= s_line_position;
            error_sum_reg  <= error_sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_free) begin
            e_reg    <= s_line_position;
            sum_reg  <= error_sum_next;
            diff_reg <= diff_next;
        end
    end

    // ------------------------------------------------------------------
    // stage b: three products in parallel
    // ------------------------------------------------------------------
    logic signed [31:0]   prod_p_reg;
    logic signed [PI_W-1:0] prod_i_reg;
    logic signed [PD_W-1:0] prod_d_reg;

    always_ff @(posedge aclk) begin
        if (b_free) begin
            prod_p_reg <= 32'(e_reg) * 32'(kp_gain_reg);
            prod_i_reg <= PI_W'(sum_reg) * PI_W'(ki_times_dt_reg);
            prod_d_reg <= PD_W'(diff_reg) * PD_W'(kd_over_dt_reg);
        end
    end

    // ------------------------------------------------------------------
    // stage c: sum, round half up to q2.14, mix with base, clamp
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0]  acc;
    logic signed [CORR_W-1:0] corr;
    logic signed [LR_W-1:0]   left_full;
    logic signed [LR_W-1:0]   right_full;
    logic signed [15:0]       left_drive_next;
    logic signed [15:0]       right_drive_next;
    logic                     clamped_next;
    logic signed [15:0]       left_drive_reg;
    logic signed [15:0]       right_drive_reg;
    logic                     clamped_reg;

    always_comb begin
        acc = ACC_W'(prod_p_reg) + ACC_W'(prod_i_reg) + ACC_W'(prod_d_reg)
            + ACC_W'(pid_lfd_pkg::ROUND_HALF);
        // dropping the fraction bits of a two's complement value is a floor
        corr       = $signed(acc[ACC_W-1:pid_lfd_pkg::GAIN_FRAC]);
        left_full  = LR_W'(cruise_reg) + LR_W'(corr);
        right_full = LR_W'(cruise_reg) - LR_W'(corr);
        clamped_next = 1'b0;

        if (left_full > LIM_HI) begin
            left_drive_next = LIM_HI[15:0];
            clamped_next    = 1'b1;
        end else if (left_full < LIM_LO) begin
            left_drive_next = LIM_LO[15:0];
            clamped_next    = 1'b1;
        end else begin
            left_drive_next = left_full[15:0];
        end

        if (right_full > LIM_HI) begin
            right_drive_next = LIM_HI[15:0];
            clamped_next     = 1'b1;
        end else if (right_full < LIM_LO) begin
            right_drive_next = LIM_LO[15:0];
            clamped_next     = 1'b1;
        end else begin
            right_drive_next = right_full[15:0];
        end
    end

    // output register, holds while the result beat is stalled
    always_ff @(posedge aclk) begin
        if (out_free) begin
            left_drive_reg  <= left_drive_next;
            right_drive_reg <= right_drive_next;
            clamped_reg     <= clamped_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_left_drive  = left_drive_reg;
    assign m_right_drive = right_drive_reg;
    assign m_clamped     = clamped_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
`ifndef ASSERT_OFF
    // drives never leave plus or minus one
    a_speed_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_left_drive <= 16'sd16384 && m_left_drive >= -16'sd16384 &&
                     m_right_drive <= 16'sd16384 && m_right_drive >= -16'sd16384))
        else $error("speed out of range");

    // a clamp flag means one side sits on a limit
    a_clamp_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_clamped) |-> (m_left_drive == 16'sd16384 ||
            m_left_drive == -16'sd16384 || m_right_drive == 16'sd16384 ||
            m_right_drive == -16'sd16384))
        else $error("clamp flag without a saturated side");

    // unclamped drives are symmetric around the base speed
    a_symmetric: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_clamped) |->
            (18'(m_left_drive) + 18'(m_right_drive) ==
             18'(cruise_reg) + 18'(cruise_reg)))
        else $error("left and right not symmetric around base");

    // previous error follows the last accepted sample
    a_prev_error: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat |=> (prev_error_reg == $past(s_line_position)))
        else $error("previous error not updated");
`endif

endmodule

>>> tb/pid_drive_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_drive_checker
// watches the sample, result and apb channels, predicts each result and
// compares it field by field with what the drive block returns
// ----------------------------------------------------------------------------
module pid_drive_checker #(
    parameter int SUM_WIDTH = 24
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic signed [15:0]                s_line_position,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic signed [15:0]                m_left_drive,
    input  logic signed [15:0]                m_right_drive,
    input  logic                              m_clamped,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pid_lfd_pkg::ADDR_W-1:0]    paddr,
    input  logic [pid_lfd_pkg::DATA_W-1:0]    pwdata,
    input  logic                              pready,
    output int                                fail_count,
    output int                                pending
);

    localparam longint SUM_MAX = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;
    localparam longint SUM_MIN = -SUM_MAX - 1;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               clamped;
    } drive_t;

    logic signed [15:0]          kp_gain;
    logic signed [15:0]          ki_times_dt;
    logic signed [15:0]          kd_over_dt;
    logic signed [15:0]          cruise;
    logic signed [15:0]          prev_error;
    logic signed [SUM_WIDTH-1:0] err_sum;

    drive_t drive_q[$];
    drive_t want;

    function automatic logic signed [15:0] limit_drive(input longint v, inout logic hit);
        if (v > pid_lfd_pkg::UNIT_ONE) begin
            hit = 1'b1;
            return 16'(pid_lfd_pkg::UNIT_ONE);
        end
        if (v < -pid_lfd_pkg::UNIT_ONE) begin
            hit = 1'b1;
            return 16'(-pid_lfd_pkg::UNIT_ONE);
        end
        return 16'(v);
    endfunction

    // one pid step: advances the error state and returns the motor drives
    function automatic drive_t pid_step(input logic signed [15:0] e);
        longint sum_next;
        longint acc;
        longint corr;
        logic   hit;
        drive_t d;
        hit = 1'b0;
        sum_next = longint'(err_sum) + longint'(e);
        if (sum_next > SUM_MAX) sum_next = SUM_MAX;
        else if (sum_next < SUM_MIN) sum_next = SUM_MIN;
        acc = longint'(kp_gain) * longint'(e)
            + longint'(ki_times_dt) * sum_next
            + longint'(kd_over_dt) * (longint'(e) - longint'(prev_error));
        // floor after adding half an lsb: round half up
        corr = (acc + pid_lfd_pkg::ROUND_HALF) >>> pid_lfd_pkg::GAIN_FRAC;
        d.left    = limit_drive(longint'(cruise) + corr, hit);
        d.right   = limit_drive(longint'(cruise) - corr, hit);
        d.clamped = hit;
        err_sum    = sum_next[SUM_WIDTH-1:0];
        prev_error = e;
        return d;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            kp_gain     = pid_lfd_pkg::KP_GAIN_RST;
            ki_times_dt = pid_lfd_pkg::KI_TIMES_DT_RST;
            kd_over_dt  = pid_lfd_pkg::KD_OVER_DT_RST;
            cruise      = pid_lfd_pkg::CRUISE_RST;
            prev_error  = '0;
            err_sum     = '0;
            drive_q.delete();
            fail_count  = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (drive_q.size() == 0) begin
                    $display("%0t: result with none expected: left %0d right %0d clamped %0b",
                             $time, m_left_drive, m_right_drive, m_clamped);
                    fail_count++;
                end else begin
                    want = drive_q.pop_front();
                    if (m_left_drive !== want.left) begin
                        $display("%0t: left drive expected %0d, got %0d",
                                 $time, want.left, m_left_drive);
                        fail_count++;
                    end
                    if (m_right_drive !== want.right) begin
                        $display("%0t: right drive expected %0d, got %0d",
                                 $time, want.right, m_right_drive);
                        fail_count++;
                    end
                    if (m_clamped !== want.clamped) begin
                        $display("%0t: clamped expected %0b, got %0b",
                                 $time, want.clamped, m_clamped);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) drive_q.insert(drive_q.size(), pid_step(s_line_position));
            if (psel && penable && pwrite && pready) begin
                case (pid_lfd_pkg::reg_index_t'(paddr[pid_lfd_pkg::ADDR_W-1:2]))
                    pid_lfd_pkg::REG_KP_GAIN:     kp_gain     = pwdata[15:0];
                    pid_lfd_pkg::REG_KI_TIMES_DT: ki_times_dt = pwdata[15:0];
                    pid_lfd_pkg::REG_KD_OVER_DT:  kd_over_dt  = pwdata[15:0];
                    pid_lfd_pkg::REG_CRUISE:      cruise      = pwdata[15:0];
                    default: ;
                endcase
            end
        end
        pending = drive_q.size();
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// line-follow pid drive: random and directed samples against a checker
// ----------------------------------------------------------------------------
// Drives line-position samples into the block under several gain and base
// speed settings written over apb, with random idle gaps on the sample side
// and random stalls on the result side. A checker beside the block predicts
// every result and counts mismatches; this module only makes stimulus and
// decides the verdict once every expected result has come back.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SUM_WIDTH    = 24;
    localparam int DRAIN_CYCLES = 8;     // idle margin after the last result in drain
    localparam int RX_HOLD      = 300;   // long result-side stall, in cycles

    logic                              aclk = 1'b0;
    logic                              aresetn;
    logic                              s_valid;
    logic                              s_ready;
    logic signed [15:0]                s_line_position;
    logic                              m_valid;
    logic                              m_ready;
    logic signed [15:0]                m_left_drive;
    logic signed [15:0]                m_right_drive;
    logic                              m_clamped;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [pid_lfd_pkg::ADDR_W-1:0]    paddr;
    logic [pid_lfd_pkg::DATA_W-1:0]    pwdata;
    logic [pid_lfd_pkg::DATA_W-1:0]    prdata;
    logic                              pready;

    int fail_count;
    int pending;

    // quiet counters: while nonzero that side runs with no idling at all
    int tx_quiet = 0;
    int rx_quiet = 0;
    bit rx_hold_req = 1'b0;

    // edge cases run at the reset gains and again at the largest gains
    localparam logic [15:0] EDGE_ERRORS [16] = '{
        16'h0000, 16'h4000, 16'hC000, 16'h4000, 16'hC000, 16'h7FFF,
        16'h8000, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF, 16'h5555,
        16'hAAAA, 16'h2000, 16'hE000, 16'h0000
    };

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    pid_line_follow_drive #(
        .SUM_WIDTH(SUM_WIDTH)
    ) uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_line_position (s_line_position),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_left_drive    (m_left_drive),
        .m_right_drive   (m_right_drive),
        .m_clamped       (m_clamped),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    pid_drive_checker #(
        .SUM_WIDTH(SUM_WIDTH)
    ) drive_chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_line_position (s_line_position),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_left_drive    (m_left_drive),
        .m_right_drive   (m_right_drive),
        .m_clamped       (m_clamped),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    // idle length: mostly none or short, a few long, and now and then a
    // quiet stretch with no gaps at all
    function automatic int draw_gap(inout int quiet);
        int r;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) quiet = $urandom_range(8, 40);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(25, 80);
    endfunction

    // line error: mostly inside +-1.0, some near zero, some at full scale,
    // and some arbitrary 16-bit patterns
    function automatic logic [15:0] draw_line_error();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 16'(int'($urandom_range(0, 2 * pid_lfd_pkg::UNIT_ONE))
                       - pid_lfd_pkg::UNIT_ONE);
        end
        if (r < 75) return 16'(int'($urandom_range(0, 512)) - 256);
        if (r < 85) begin
            case ($urandom_range(0, 2))
                0:       return 16'(pid_lfd_pkg::UNIT_ONE);
                1:       return 16'(-pid_lfd_pkg::UNIT_ONE);
                default: return 16'h0000;
            endcase
        end
        return 16'($urandom);
    endfunction

    // value within +-span most of the time, else any 16-bit pattern
    function automatic logic [15:0] draw_setting(input int span);
        if ($urandom_range(0, 7) == 0) return 16'($urandom);
        return 16'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // one sample beat; returns at the edge where it is accepted
    task automatic send_sample(input logic [15:0] err);
        int gap;
        gap = draw_gap(tx_quiet);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_line_position <= err;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // stop offering samples and wait until every result has come back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // setup cycle, access cycle, then idle before anything else
    task automatic apb_write(input pid_lfd_pkg::reg_index_t idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), value};   // upper half is don't-care
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // registers are only touched with the pipeline empty
    task automatic load_gains(input logic [15:0] kp, input logic [15:0] ki,
                              input logic [15:0] kd, input logic [15:0] base);
        drain();
        apb_write(pid_lfd_pkg::REG_KP_GAIN, kp);
        apb_write(pid_lfd_pkg::REG_KI_TIMES_DT, ki);
        apb_write(pid_lfd_pkg::REG_KD_OVER_DT, kd);
        apb_write(pid_lfd_pkg::REG_CRUISE, base);
    endtask

    // random samples; at index hold_at the result side stalls for a long
    // stretch while samples keep coming back to back
    task automatic run_random(input int count, input int hold_at);
        for (int i = 0; i < count; i++) begin
            if (i == hold_at) begin
                rx_hold_req = 1'b1;
                tx_quiet    = 40;
            end
            send_sample(draw_line_error());
        end
    endtask

    // result side: ready with random stalls, plus the long hold on request
    initial begin : result_sink
        int gap;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (rx_hold_req) begin
                m_ready <= 1'b0;
                repeat (RX_HOLD) @(posedge aclk);
                rx_hold_req = 1'b0;
            end else begin
                gap = draw_gap(rx_quiet);
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // safety net against a hung handshake
    initial begin : watchdog
        #(20_000_000);
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        bit          climb;
        logic [15:0] err;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_line_position = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // edge cases at the reset gains: full-scale steps, out-of-range
        // errors, sign flips for a large derivative term
        foreach (EDGE_ERRORS[i]) send_sample(EDGE_ERRORS[i]);

        // moderate random gains, with one long output stall
        load_gains(draw_setting(512), draw_setting(32), draw_setting(512),
                   draw_setting(pid_lfd_pkg::UNIT_ONE));
        run_random(100, 40);

        // largest positive gains and base at +1.0: clamps almost everywhere
        load_gains(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'(pid_lfd_pkg::UNIT_ONE));
        foreach (EDGE_ERRORS[i]) send_sample(EDGE_ERRORS[i]);
        run_random(60, -1);

        // most negative gains and base at -1.0
        load_gains(16'h8000, 16'h8000, 16'h8000, 16'(-pid_lfd_pkg::UNIT_ONE));
        run_random(70, -1);

        // drive the error sum into saturation in a random direction; with
        // kp = -1.0 and ki = 1/256 the correction shows the exact sum limit
        load_gains(16'(-256), 16'd1, 16'd0, 16'd0);
        climb = 1'($urandom_range(0, 1));
        for (int i = 0; i < 280; i++) begin
            if (climb) err = 16'(32767 - int'($urandom_range(0, 63)));
            else       err = 16'(-32768 + int'($urandom_range(0, 63)));
            send_sample(err);
        end
        run_random(20, -1);

        // base speed beyond 1.0 and random gains, another long stall
        load_gains(draw_setting(512), draw_setting(32), draw_setting(512), 16'h7FFF);
        run_random(80, 20);

        drain();
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/pid_lfd_pkg.sv
design/pid_line_follow_drive.sv
tb/pid_drive_checker.sv
tb/testbench.sv
